// ===== rtl/qrf_pkg.sv =====
// ----------------------------------------------------------------------------
// qrf_pkg
// Shared widths, status codes and the line snapshot type of the finder check.
// ----------------------------------------------------------------------------
package qrf_pkg;

  localparam int PIX_W  = 8;            // pixel width
  localparam int LEN_W  = 13;           // run length / run count width
  localparam int ST_W   = 2;            // status code width
  localparam int OUT_W  = 8;            // result tdata width (byte padded)

  // run lengths and run count saturate here
  localparam logic [LEN_W-1:0] MAX_LINE = LEN_W'(4096);
  // a finder line needs at least this many runs
  localparam logic [LEN_W-1:0] MIN_RUNS = LEN_W'(5);

  // verdict codes
  localparam logic [ST_W-1:0] ST_PASS     = 2'd0;
  localparam logic [ST_W-1:0] ST_FEW_RUNS = 2'd1;
  localparam logic [ST_W-1:0] ST_EDGE     = 2'd2;
  localparam logic [ST_W-1:0] ST_RATIO    = 2'd3;

  // what the verdict stage needs of a finished line
  typedef struct packed {
    logic             few_runs;   // fewer than MIN_RUNS runs
    logic             near_edge;  // fewer than two runs on one side of longest
    logic [LEN_W-1:0] longest;
    logic [LEN_W-1:0] before0;    // adjacent to longest
    logic [LEN_W-1:0] before1;
    logic [LEN_W-1:0] after0;     // adjacent to longest
    logic [LEN_W-1:0] after1;
  } line_snap_t;

endpackage

// ===== rtl/qrf_run_track.sv =====
// ----------------------------------------------------------------------------
// qrf_run_track
// Run-length codes the line, tracks the longest run and its neighbors, and
// registers a snapshot of the line at its last pixel.
// ----------------------------------------------------------------------------
module qrf_run_track
  import qrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,        // one pixel is consumed this cycle
  input  logic [PIX_W-1:0] pixel,
  input  logic             line_end,
  input  logic             snap_ready,  // verdict stage takes the snapshot
  output logic             snap_valid,
  output line_snap_t       snap
);

  typedef struct packed {
    logic             color;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] runs_done;
    logic [LEN_W-1:0] recent0;    // newest closed run
    logic [LEN_W-1:0] recent1;
    logic [LEN_W-1:0] longest;
    logic [LEN_W-1:0] pos;        // index of the longest run
    logic [LEN_W-1:0] before0;
    logic [LEN_W-1:0] before1;
    logic [LEN_W-1:0] after0;
    logic [LEN_W-1:0] after1;
    logic [1:0]       captured;   // runs held after the longest
  } line_state_t;

  function automatic line_state_t close_run(line_state_t s, logic [LEN_W-1:0] len);
    line_state_t r;
    r = s;
    if (s.runs_done == '0 || len > s.longest) begin
      r.longest  = len;
      r.pos      = s.runs_done;
      r.before0  = s.recent0;
      r.before1  = s.recent1;
      r.after0   = '0;
      r.after1   = '0;
      r.captured = '0;
    end else if (s.captured < 2'd2) begin
      if (s.captured[0]) begin
        r.after1 = len;
      end else begin
        r.after0 = len;
      end
      r.captured = s.captured + 2'd1;
    end
    r.recent1 = s.recent0;
    r.recent0 = len;
    if (s.runs_done < MAX_LINE) begin
      r.runs_done = s.runs_done + LEN_W'(1);
    end
    return r;
  endfunction

  line_state_t state;
  line_state_t state_next;
  line_state_t upd;       // after this pixel
  line_state_t fin;       // after closing the last run
  line_snap_t  snap_next;
  logic        color;

  assign color = |pixel;

  always_comb begin
    upd = state;
    if (state.cur_len == '0) begin
      upd.color   = color;
      upd.cur_len = LEN_W'(1);
    end else if (color != state.color) begin
      upd         = close_run(state, state.cur_len);
      upd.color   = color;
      upd.cur_len = LEN_W'(1);
    end else if (state.cur_len < MAX_LINE) begin
      upd.cur_len = state.cur_len + LEN_W'(1);
    end

    fin = close_run(upd, upd.cur_len);

    snap_next.few_runs  = fin.runs_done < MIN_RUNS;
    snap_next.near_edge = (fin.pos < LEN_W'(2)) || (fin.captured < 2'd2);
    snap_next.longest   = fin.longest;
    snap_next.before0   = fin.before0;
    snap_next.before1   = fin.before1;
    snap_next.after0    = fin.after0;
    snap_next.after1    = fin.after1;

    state_next = line_end ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (step) begin
        state <= state_next;
      end
      if (step && line_end) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && line_end) begin
      snap <= snap_next;
    end
  end

  a_captured_max: assert property (@(posedge clk) disable iff (rst)
    state.captured <= 2'd2)
    else $error("more than two runs held after the longest");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    state.cur_len <= MAX_LINE && state.runs_done <= MAX_LINE)
    else $error("run length or run count past saturation");

  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_ready |=> snap_valid && $stable(snap))
    else $error("snapshot lost while verdict stage stalled");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    step && line_end |=> state.cur_len == '0 && state.runs_done == '0)
    else $error("line state not cleared after last pixel");

endmodule

// ===== rtl/qrf_verdict.sv =====
// ----------------------------------------------------------------------------
// qrf_verdict
// Grades a finished line against the 1:1:3:1:1 ratio and holds the result.
// ----------------------------------------------------------------------------
module qrf_verdict
  import qrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             snap_valid,
  input  line_snap_t       snap,
  output logic             snap_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  localparam int PROD_W = LEN_W + 4;  // holds 15 * run length

  // exact form of 0.40 < c / (max / 3) < 2.25
  function automatic logic ratio_ok(logic [LEN_W-1:0] c, logic [LEN_W-1:0] mx);
    logic [PROD_W-1:0] c15;
    logic [PROD_W-1:0] m2;
    logic [PROD_W-1:0] c4;
    logic [PROD_W-1:0] m3;
    c15 = (PROD_W'(c) << 4) - PROD_W'(c);
    m2  = PROD_W'(mx) << 1;
    c4  = PROD_W'(c) << 2;
    m3  = (PROD_W'(mx) << 1) + PROD_W'(mx);
    return (c15 > m2) && (c4 < m3);
  endfunction

  logic            all_ok;
  logic [ST_W-1:0] status;

  assign all_ok = ratio_ok(snap.before0, snap.longest) &&
                  ratio_ok(snap.before1, snap.longest) &&
                  ratio_ok(snap.after0,  snap.longest) &&
                  ratio_ok(snap.after1,  snap.longest);

  always_comb begin
    if (snap.few_runs) begin
      status = ST_FEW_RUNS;
    end else if (snap.near_edge) begin
      status = ST_EDGE;
    end else if (!all_ok) begin
      status = ST_RATIO;
    end else begin
      status = ST_PASS;
    end
  end

  assign snap_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (snap_ready) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      m_tdata <= {(OUT_W-ST_W-1)'(0), status, status == ST_PASS};
    end
  end

endmodule

// ===== rtl/qr_finder_ratio_line_check_unit.sv =====
// ----------------------------------------------------------------------------
// qr_finder_ratio_line_check_unit
// Checks one image line per frame of pixels for the QR finder 1:1:3:1:1 run
// pattern and returns one verdict per line.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-------------------------------------
//   s_*     | in  | s_tvalid / s_tready | s_tdata = pixel, s_tlast = line_end
//   m_*     | out | m_tvalid / m_tready | m_tdata = finder_ok, status
//
// One pixel request per clock, pixels back to back, unless a stall on m_*
// holds a last pixel. Path from the last pixel's request to its verdict:
// input register, run tracker with line snapshot, verdict register.
// The run tracker's per-pixel update (compare, up to two run closes) is the
// loop that sets the one-pixel-per-clock figure.
// rst (synchronous) clears the line state and all valid flags.
// A stall on m_* stops intake only when a line's last pixel waits while the
// snapshot and the verdict register both still hold earlier lines.
//
module qr_finder_ratio_line_check_unit
  import qrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [PIX_W-1:0] s_tdata,   // [7:0] pixel
  input  logic             s_tlast,   // line_end
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [0] finder_ok, [2:1] status, [7:3] zero
);

  // input register
  logic             in_valid;
  logic [PIX_W-1:0] in_pixel;
  logic             in_last;
  logic             in_adv;

  // snapshot handoff
  logic       snap_valid;
  logic       snap_ready;
  line_snap_t snap;

  // a plain pixel always moves; a last pixel needs room for its snapshot
  assign in_adv   = in_valid && (!in_last || !snap_valid || snap_ready);
  assign s_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pixel <= s_tdata;
      in_last  <= s_tlast;
    end
  end

  qrf_run_track u_run_track (
    .clk        (clk),
    .rst        (rst),
    .step       (in_adv),
    .pixel      (in_pixel),
    .line_end   (in_last),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  qrf_verdict u_verdict (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ===== bench/qrf_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrf_verdict_checker
// Watches both streams of the finder line check, tracks the runs of each line
// on its own and checks every verdict against the predicted one in order.
// ----------------------------------------------------------------------------
module qrf_verdict_checker
  import qrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [PIX_W-1:0] s_tdata,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic            finder_ok;
    logic [ST_W-1:0] status;
  } verdict_t;

  verdict_t         verdict_q[$];
  verdict_t         want_v;

  // run tracker of the line in progress
  logic             cur_color;
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] run_count;
  logic [LEN_W-1:0] recent[2];   // [0] newest closed run
  logic [LEN_W-1:0] top_len;
  logic [LEN_W-1:0] top_pos;
  logic [LEN_W-1:0] pre[2];      // [0] adjacent to longest
  logic [LEN_W-1:0] post[2];     // [0] adjacent to longest
  logic [1:0]       post_cnt;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void clear_line();
    cur_color = 1'b0;
    cur_len   = '0;
    run_count = '0;
    recent[0] = '0;
    recent[1] = '0;
    top_len   = '0;
    top_pos   = '0;
    pre[0]    = '0;
    pre[1]    = '0;
    post[0]   = '0;
    post[1]   = '0;
    post_cnt  = '0;
  endfunction

  function automatic void retire_run(input logic [LEN_W-1:0] len);
    if (run_count == 0 || len > top_len) begin
      // new longest; first one wins ties
      top_len  = len;
      top_pos  = run_count;
      pre[0]   = recent[0];
      pre[1]   = recent[1];
      post[0]  = '0;
      post[1]  = '0;
      post_cnt = '0;
    end else if (post_cnt < 2) begin
      post[post_cnt[0]] = len;
      post_cnt++;
    end
    recent[1] = recent[0];
    recent[0] = len;
    if (run_count < MAX_LINE)
      run_count++;
  endfunction

  // 0.40 < c / (max / 3) < 2.25 in integers
  function automatic bit ratio_fits(input logic [LEN_W-1:0] c,
                                    input logic [LEN_W-1:0] longest);
    int unsigned cv;
    int unsigned mv;
    cv = c;
    mv = longest;
    return (15 * cv > 2 * mv) && (4 * cv < 3 * mv);
  endfunction

  function automatic logic [ST_W-1:0] judge_line();
    if (run_count < MIN_RUNS)
      return ST_FEW_RUNS;
    if (top_pos < 2 || post_cnt < 2)
      return ST_EDGE;
    if (!ratio_fits(pre[0], top_len) || !ratio_fits(pre[1], top_len) ||
        !ratio_fits(post[0], top_len) || !ratio_fits(post[1], top_len))
      return ST_RATIO;
    return ST_PASS;
  endfunction

  function automatic void take_pixel(input logic [PIX_W-1:0] px, input logic last);
    logic            color;
    logic [ST_W-1:0] st;
    verdict_t        v;
    color = (px != '0);
    if (cur_len == 0) begin
      cur_color = color;
      cur_len   = LEN_W'(1);
    end else if (color != cur_color) begin
      retire_run(cur_len);
      cur_color = color;
      cur_len   = LEN_W'(1);
    end else if (cur_len < MAX_LINE) begin
      cur_len++;
    end
    if (last) begin
      retire_run(cur_len);
      st          = judge_line();
      v.finder_ok = (st == ST_PASS);
      v.status    = st;
      verdict_q.insert(verdict_q.size(), v);
      clear_line();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      verdict_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict 0x%h with no line pending", m_tdata));
        end else begin
          want_v = verdict_q.pop_front();
          if (m_tdata[0] !== want_v.finder_ok)
            report_mismatch($sformatf("finder_ok got %b, expected %b",
                                      m_tdata[0], want_v.finder_ok));
          if (m_tdata[2:1] !== want_v.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      m_tdata[2:1], want_v.status));
          if (m_tdata[OUT_W-1:3] !== '0)
            report_mismatch($sformatf("pad bits got 0x%h, expected 0",
                                      m_tdata[OUT_W-1:3]));
        end
      end
      if (s_tvalid && s_tready)
        take_pixel(s_tdata, s_tlast);
    end
    outstanding = verdict_q.size();
  end

endmodule

// ===== bench/qr_finder_ratio_line_check_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_finder_ratio_line_check_unit_test
// Drives image lines into the finder ratio check as pixel requests and lets
// the checker compare every verdict. Directed lines first, then random
// finder-shaped, boundary, short and noise lines.
// ----------------------------------------------------------------------------
module qr_finder_ratio_line_check_unit_test;
  import qrf_pkg::*;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [PIX_W-1:0] s_tdata;    // [7:0] pixel
  logic             s_tlast;    // line_end
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;    // [0] finder_ok, [2:1] status, [7:3] zero

  int  fail_count;
  int  outstanding;             // verdicts still owed by the block
  bit  tx_idle;                 // sender may insert gaps
  bit  rx_idle;                 // receiver may stall
  int  pixels_sent;
  int  line_runs[$];            // run lengths of the next line, in order
  int  random_goal;
  int  pick;

  qr_finder_ratio_line_check_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  qrf_verdict_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Slowest legal run is well under 2 ms; give it several times that.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Verdict side: random stall bursts while rx_idle is set.
  // Stalls are frequent so that back-to-back short lines fill the pipe.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // One pixel request; returns at the edge that accepted it. tvalid stays
  // high into the next request unless a gap burst is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic last);
    if (tx_idle && $urandom_range(0, 11) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Sends line_runs as alternating color runs; white pixels get random
  // nonzero values so every pixel bit toggles.
  task automatic send_line(input bit white_first);
    int               k;
    int               n;
    bit               color;
    logic [PIX_W-1:0] px;
    color = white_first;
    for (k = 0; k < line_runs.size(); k++) begin
      for (n = 0; n < line_runs[k]; n++) begin
        px = color ? PIX_W'($urandom_range(1, 255)) : '0;
        send_pixel(px, (k == line_runs.size() - 1) && (n == line_runs[k] - 1));
      end
      color = ~color;
    end
  endtask

  // Raw pixels, half of them black.
  task automatic send_noise_line(input int len);
    int               n;
    logic [PIX_W-1:0] px;
    for (n = 0; n < len; n++) begin
      px = $urandom_range(0, 1) ? PIX_W'($urandom_range(0, 255)) : '0;
      send_pixel(px, n == len - 1);
    end
  endtask

  // Stop requesting until every verdict has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // append one run to the next line
  function automatic void add_run(input int len);
    line_runs.insert(line_runs.size(), len);
  endfunction

  function automatic void runs5(input int a, input int b, input int c,
                                input int d, input int e);
    line_runs.delete();
    add_run(a);
    add_run(b);
    add_run(c);
    add_run(d);
    add_run(e);
  endfunction

  function automatic int jitter(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, spread) - $urandom_range(0, spread);
    return (v < 1) ? 1 : v;
  endfunction

  // Optional random runs, then a rough 1:1:3:1:1 core, then more runs.
  task automatic make_finder_runs();
    int u;
    int k;
    u = $urandom_range(1, 6);
    line_runs.delete();
    repeat ($urandom_range(0, 3)) add_run($urandom_range(1, 2 * u + 1));
    for (k = 0; k < 5; k++)
      add_run(jitter((k == 2) ? 3 * u : u, u / 2 + 1));
    repeat ($urandom_range(0, 3)) add_run($urandom_range(1, 2 * u + 1));
  endtask

  // Neighbours sit right at or next to the two ratio limits.
  function automatic int edge_neighbour(input int m);
    int lo;
    int hi;
    int c;
    lo = (2 * m) / 15;          // 15*lo <= 2*m: just too small
    hi = (3 * m + 3) / 4;       // 4*hi >= 3*m: just too large
    case ($urandom_range(0, 3))
      0: c = lo;
      1: c = lo + 1;
      2: c = hi - 1;
      default: c = hi;
    endcase
    return (c < 1) ? 1 : c;
  endfunction

  task automatic make_boundary_runs();
    int m;
    m = $urandom_range(4, 60);
    runs5(edge_neighbour(m), edge_neighbour(m), m, edge_neighbour(m), edge_neighbour(m));
  endtask

  task automatic make_short_runs();
    line_runs.delete();
    repeat ($urandom_range(1, 6)) add_run($urandom_range(1, 3));
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed lines -----------------------------------------------------
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // one-pixel lines, white and black: a single run
    line_runs.delete();
    add_run(1);
    send_line(1'b1);
    send_pixel(PIX_W'(0), 1'b1);
    // clean finder pattern
    runs5(1, 1, 3, 1, 1);
    send_line(1'b0);
    // longest run first: too near the edge
    runs5(3, 1, 1, 1, 1);
    send_line(1'b1);
    // neighbours too thin, then too wide
    runs5(1, 1, 8, 1, 1);
    send_line(1'b0);
    runs5(3, 3, 4, 3, 3);
    send_line(1'b1);
    // hold off until the pipe is empty
    drain();

    // --- random lines -------------------------------------------------------
    random_goal = pixels_sent + 700;
    while (pixels_sent < random_goal) begin
      // idling comes and goes by line, and stops for the last stretch
      if (random_goal - pixels_sent > 150) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end else begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)
        make_finder_runs();
      else if (pick < 70)
        make_boundary_runs();
      else if (pick < 85)
        make_short_runs();
      if (pick < 85)
        send_line($urandom_range(0, 1));
      else
        send_noise_line($urandom_range(1, 40));
    end

    drain();
    // leave room for anything stray
    repeat (12) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qrf_pkg.sv
rtl/qrf_run_track.sv
rtl/qrf_verdict.sv
rtl/qr_finder_ratio_line_check_unit.sv
bench/qrf_verdict_checker.sv
bench/qr_finder_ratio_line_check_unit_test.sv
